FILE: src/llsf_pkg.sv
// ----------------------------------------------------------------------------
// llsf_pkg: shared types and constants
// Field widths, default store depth and the sequencer codes of the line fit.
// ----------------------------------------------------------------------------
package llsf_pkg;

  localparam int DefMaxPoints = 1024;
  localparam int CoordW       = 16;
  localparam int ResW         = 32;
  localparam int ChiW         = 48;

  typedef enum logic [7:0] {
    ST_IDLE  = 8'b0000_0001,
    ST_MLOAD = 8'b0000_0010,
    ST_MRUN  = 8'b0000_0100,
    ST_DLOAD = 8'b0000_1000,
    ST_DRUN  = 8'b0001_0000,
    ST_RREAD = 8'b0010_0000,
    ST_RCALC = 8'b0100_0000,
    ST_DONE  = 8'b1000_0000
  } state_e;

  typedef enum logic [2:0] {
    J_NSXY  = 3'd0,
    J_SXSY  = 3'd1,
    J_NSXX  = 3'd2,
    J_SXSX  = 3'd3,
    J_SLOPE = 3'd4,
    J_SSX   = 3'd5,
    J_ICPT  = 3'd6,
    J_RR    = 3'd7
  } job_e;

endpackage

FILE: src/llsf_if.sv
// ----------------------------------------------------------------------------
// llsf channel interfaces
// Point input channel and fit result channel, valid/ready handshake.
// ----------------------------------------------------------------------------
interface llsf_pt_if import llsf_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic signed [CoordW-1:0] x_value;
  logic signed [CoordW-1:0] y_value;
  logic                     last_point;

  modport source (output valid, x_value, y_value, last_point, input ready);
  modport sink   (input valid, x_value, y_value, last_point, output ready);
endinterface

interface llsf_fit_if import llsf_pkg::*; ();
  logic                   valid;
  logic                   ready;
  logic signed [ResW-1:0] slope;
  logic signed [ResW-1:0] intercept;
  logic [ChiW-1:0]        chi_squared;
  logic                   fit_ok;

  modport source (output valid, slope, intercept, chi_squared, fit_ok, input ready);
  modport sink   (input valid, slope, intercept, chi_squared, fit_ok, output ready);
endinterface

FILE: src/linear_least_squares_fit.sv
// ----------------------------------------------------------------------------
// linear_least_squares_fit: straight line fit over a set of Q8.8 points
// Points are taken one word per cycle while the block is idle, stored and
// summed. The word flagged as last starts the fit: a shift-add multiplier
// and a restoring divider, each one bit per cycle under a small sequencer,
// form slope and intercept, then every stored point is read back and its
// squared residual summed. No point is taken while a fit runs or while its
// result waits for the output register to free. A finished result waits in
// the output register while the next set is loaded. A zero denominator
// gives fit_ok low and zero results.
// ----------------------------------------------------------------------------
module linear_least_squares_fit import llsf_pkg::*; #(
  parameter int MAX_POINTS = DefMaxPoints
) (
  input  logic clk_i,
  input  logic rst_ni,
  llsf_pt_if.sink    pt_i,
  llsf_fit_if.source fit_o
);

  localparam int CW   = $clog2(MAX_POINTS + 1);
  localparam int AW   = $clog2(MAX_POINTS);
  localparam int SXW  = CoordW + CW;
  localparam int SQW  = 31 + CW;
  localparam int RW   = 48;
  localparam int MW   = (SQW > RW - 1) ? SQW : RW - 1;
  localparam int PW   = 2 * MW;
  localparam int NW   = 33 + 2 * CW;
  localparam int DVW  = NW + 16;
  localparam int DCW  = $clog2(DVW + 1);
  localparam int ACW  = PW + CW;

  state_e state_q, state_d;
  job_e   job_q, job_d;

  logic [CW-1:0]         count_q, count_d, idx_q, idx_d;
  logic signed [SXW-1:0] sx_q, sx_d, sy_q, sy_d;
  logic signed [SQW-1:0] sxx_q, sxx_d, sxy_q, sxy_d;
  logic signed [NW-1:0]  t_q, t_d;
  logic signed [DVW-1:0] num_q, num_d;
  logic [DVW-1:0]        den_q, den_d;
  logic signed [ResW-1:0] slope_q, slope_d, icpt_q, icpt_d;
  logic [ACW-1:0]        acc_q, acc_d;
  logic                  ok_q, ok_d;

  logic [PW-1:0]  mcand_q, mcand_d, prod_q, prod_d;
  logic [MW-1:0]  mplier_q, mplier_d;
  logic           mneg_q, mneg_d;

  logic [DVW-1:0] dq_q, dq_d, dd_q, dd_d;
  logic [DVW:0]   rem_q, rem_d;
  logic           dneg_q, dneg_d;
  logic [DCW-1:0] dcnt_q, dcnt_d;

  logic                   ovalid_q, ovalid_d;
  logic signed [ResW-1:0] oslope_q, oslope_d, oicpt_q, oicpt_d;
  logic [ChiW-1:0]        ochi_q, ochi_d;
  logic                   ook_q, ook_d;

  logic [2*CoordW-1:0] mem [MAX_POINTS];
  logic [2*CoordW-1:0] rdata_q;
  logic                mem_we, mem_re;

  logic signed [2*CoordW-1:0] xx_c, xy_c;
  logic signed [MW:0]         ld_a, ld_b;
  logic signed [PW:0]         pres;
  logic signed [NW-1:0]       diff_c;
  logic signed [RW-1:0]       sxp_c, r_c;
  logic signed [CoordW-1:0]   rx_c, ry_c;
  logic [DVW:0]               rs_c;
  logic                       ge_c;
  logic [DVW-1:0]             quo_c;
  logic signed [ResW-1:0]     sat_c;

  assign pt_i.ready        = (state_q == ST_IDLE);
  assign fit_o.valid       = ovalid_q;
  assign fit_o.slope       = oslope_q;
  assign fit_o.intercept   = oicpt_q;
  assign fit_o.chi_squared = ochi_q;
  assign fit_o.fit_ok      = ook_q;

  assign xx_c = pt_i.x_value * pt_i.x_value;
  assign xy_c = pt_i.x_value * pt_i.y_value;

  assign rx_c  = rdata_q[2*CoordW-1:CoordW];
  assign ry_c  = rdata_q[CoordW-1:0];
  assign sxp_c = slope_q * rx_c;
  assign r_c   = sxp_c + (RW'(icpt_q) <<< 8) - (RW'(ry_c) <<< 16);

  assign pres   = mneg_q ? -$signed({1'b0, prod_q}) : $signed({1'b0, prod_q});
  assign diff_c = t_q - pres[NW-1:0];

  assign rs_c  = {rem_q[DVW-1:0], dq_q[DVW-1]};
  assign ge_c  = (rs_c >= {1'b0, dd_q});
  assign quo_c = {dq_q[DVW-2:0], ge_c};

  always_comb begin
    if (dneg_q) begin
      if (quo_c > DVW'(64'h8000_0000)) sat_c = {1'b1, {(ResW-1){1'b0}}};
      else                             sat_c = -$signed(quo_c[ResW-1:0]);
    end else begin
      if (quo_c > DVW'(64'h7FFF_FFFF)) sat_c = {1'b0, {(ResW-1){1'b1}}};
      else                             sat_c = $signed(quo_c[ResW-1:0]);
    end
  end

  always_comb begin
    if (state_q == ST_RCALC) begin
      ld_a = (MW+1)'(r_c);
      ld_b = (MW+1)'(r_c);
    end else begin
      unique case (job_q)
        J_NSXY:  begin ld_a = (MW+1)'(count_q); ld_b = (MW+1)'(sxy_q); end
        J_SXSY:  begin ld_a = (MW+1)'(sx_q);    ld_b = (MW+1)'(sy_q);  end
        J_NSXX:  begin ld_a = (MW+1)'(count_q); ld_b = (MW+1)'(sxx_q); end
        J_SXSX:  begin ld_a = (MW+1)'(sx_q);    ld_b = (MW+1)'(sx_q);  end
        J_SSX:   begin ld_a = (MW+1)'(slope_q); ld_b = (MW+1)'(sx_q);  end
        default: begin ld_a = '0;               ld_b = '0;             end
      endcase
    end
  end

  always_comb begin
    state_d  = state_q;   job_d    = job_q;
    count_d  = count_q;   idx_d    = idx_q;
    sx_d     = sx_q;      sy_d     = sy_q;
    sxx_d    = sxx_q;     sxy_d    = sxy_q;
    t_d      = t_q;       num_d    = num_q;    den_d = den_q;
    slope_d  = slope_q;   icpt_d   = icpt_q;
    acc_d    = acc_q;     ok_d     = ok_q;
    mcand_d  = mcand_q;   prod_d   = prod_q;
    mplier_d = mplier_q;  mneg_d   = mneg_q;
    dq_d     = dq_q;      dd_d     = dd_q;     rem_d = rem_q;
    dneg_d   = dneg_q;    dcnt_d   = dcnt_q;
    ovalid_d = ovalid_q;  oslope_d = oslope_q;
    oicpt_d  = oicpt_q;   ochi_d   = ochi_q;   ook_d = ook_q;
    mem_we   = 1'b0;      mem_re   = 1'b0;

    if (ovalid_q && fit_o.ready) ovalid_d = 1'b0;

    unique case (state_q)
      ST_IDLE: begin
        if (pt_i.valid) begin
          if (count_q < CW'(MAX_POINTS)) begin
            mem_we  = 1'b1;
            count_d = count_q + 1'b1;
            sx_d    = sx_q + SXW'(pt_i.x_value);
            sy_d    = sy_q + SXW'(pt_i.y_value);
            sxx_d   = sxx_q + SQW'(xx_c);
            sxy_d   = sxy_q + SQW'(xy_c);
          end
          if (pt_i.last_point) begin
            job_d   = J_NSXY;
            state_d = ST_MLOAD;
          end
        end
      end
      ST_MLOAD, ST_RCALC: begin
        mneg_d   = ld_a[MW] ^ ld_b[MW];
        mcand_d  = PW'(ld_a[MW] ? MW'(-ld_a) : MW'(ld_a));
        mplier_d = ld_b[MW] ? MW'(-ld_b) : MW'(ld_b);
        prod_d   = '0;
        state_d  = ST_MRUN;
      end
      ST_MRUN: begin
        if (mplier_q != '0) begin
          if (mplier_q[0]) prod_d = prod_q + mcand_q;
          mcand_d  = mcand_q << 1;
          mplier_d = mplier_q >> 1;
        end else begin
          unique case (job_q)
            J_NSXY: begin
              t_d = pres[NW-1:0]; job_d = J_SXSY; state_d = ST_MLOAD;
            end
            J_SXSY: begin
              num_d = {diff_c, 16'b0}; job_d = J_NSXX; state_d = ST_MLOAD;
            end
            J_NSXX: begin
              t_d = pres[NW-1:0]; job_d = J_SXSX; state_d = ST_MLOAD;
            end
            J_SXSX: begin
              if (!diff_c[NW-1] && diff_c != '0) begin
                den_d   = DVW'($unsigned(diff_c));
                ok_d    = 1'b1;
                job_d   = J_SLOPE;
                state_d = ST_DLOAD;
              end else begin
                ok_d    = 1'b0;
                slope_d = '0;
                icpt_d  = '0;
                acc_d   = '0;
                state_d = ST_DONE;
              end
            end
            J_SSX: begin
              num_d   = (DVW'(sy_q) <<< 16) - pres[DVW-1:0];
              den_d   = DVW'({count_q, 8'b0});
              job_d   = J_ICPT;
              state_d = ST_DLOAD;
            end
            J_RR: begin
              acc_d = acc_q + ACW'(prod_q);
              idx_d = idx_q + 1'b1;
              if (idx_q + 1'b1 == count_q) state_d = ST_DONE;
              else                         state_d = ST_RREAD;
            end
            default: state_d = ST_DONE;
          endcase
        end
      end
      ST_DLOAD: begin
        dneg_d  = num_q[DVW-1];
        dq_d    = num_q[DVW-1] ? DVW'(-num_q) : DVW'(num_q);
        dd_d    = den_q;
        rem_d   = '0;
        dcnt_d  = DCW'(DVW);
        state_d = ST_DRUN;
      end
      ST_DRUN: begin
        rem_d  = ge_c ? rs_c - {1'b0, dd_q} : rs_c;
        dq_d   = quo_c;
        dcnt_d = dcnt_q - 1'b1;
        if (dcnt_q == DCW'(1)) begin
          if (job_q == J_SLOPE) begin
            slope_d = sat_c;
            job_d   = J_SSX;
            state_d = ST_MLOAD;
          end else begin
            icpt_d  = sat_c;
            idx_d   = '0;
            acc_d   = '0;
            job_d   = J_RR;
            state_d = ST_RREAD;
          end
        end
      end
      ST_RREAD: begin
        mem_re  = 1'b1;
        state_d = ST_RCALC;
      end
      ST_DONE: begin
        if (!ovalid_q || fit_o.ready) begin
          ovalid_d = 1'b1;
          oslope_d = slope_q;
          oicpt_d  = icpt_q;
          ook_d    = ok_q;
          if (acc_q[ACW-1:80] != '0) ochi_d = '1;
          else                       ochi_d = acc_q[79:32];
          count_d  = '0;
          sx_d     = '0;
          sy_d     = '0;
          sxx_d    = '0;
          sxy_d    = '0;
          state_d  = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      job_q    <= J_NSXY;
      count_q  <= '0;
      sx_q     <= '0;
      sy_q     <= '0;
      sxx_q    <= '0;
      sxy_q    <= '0;
      ok_q     <= 1'b0;
      ovalid_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      job_q    <= job_d;
      count_q  <= count_d;
      sx_q     <= sx_d;
      sy_q     <= sy_d;
      sxx_q    <= sxx_d;
      sxy_q    <= sxy_d;
      ok_q     <= ok_d;
      ovalid_q <= ovalid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    idx_q    <= idx_d;
    t_q      <= t_d;
    num_q    <= num_d;
    den_q    <= den_d;
    slope_q  <= slope_d;
    icpt_q   <= icpt_d;
    acc_q    <= acc_d;
    mcand_q  <= mcand_d;
    prod_q   <= prod_d;
    mplier_q <= mplier_d;
    mneg_q   <= mneg_d;
    dq_q     <= dq_d;
    dd_q     <= dd_d;
    rem_q    <= rem_d;
    dneg_q   <= dneg_d;
    dcnt_q   <= dcnt_d;
    oslope_q <= oslope_d;
    oicpt_q  <= oicpt_d;
    ochi_q   <= ochi_d;
    ook_q    <= ook_d;
  end

  // point store, registered read
  always_ff @(posedge clk_i) begin
    if (mem_we) mem[count_q[AW-1:0]] <= {pt_i.x_value, pt_i.y_value};
    if (mem_re) rdata_q <= mem[idx_q[AW-1:0]];
  end

endmodule

FILE: tb/tb_linear_least_squares_fit.sv
// ----------------------------------------------------------------------------
// tb_linear_least_squares_fit: self-checking bench for the straight line fit
// Point words are queued by a stimulus process, driven under random gaps and
// predicted on the fly. Fit words are taken under random stalls and compared
// field by field with the predicted fits, oldest first.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_linear_least_squares_fit import llsf_pkg::*; ();

  localparam int  Depth   = DefMaxPoints;
  localparam longint Limit = 3000000;

  typedef struct packed {
    logic signed [CoordW-1:0] x;
    logic signed [CoordW-1:0] y;
    logic                     last;
  } point_t;

  typedef struct packed {
    logic signed [ResW-1:0] slope;
    logic signed [ResW-1:0] intercept;
    logic [ChiW-1:0]        chi;
    logic                   ok;
  } fit_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  longint cycles = 0;
  int     errors = 0;

  point_t point_q[$];
  fit_t   fit_q[$];

  logic signed [CoordW-1:0] x_mem [Depth];
  logic signed [CoordW-1:0] y_mem [Depth];
  longint n_pts = 0, s_x = 0, s_y = 0, s_xx = 0, s_xy = 0;

  llsf_pt_if  pt ();
  llsf_fit_if fit ();

  linear_least_squares_fit #(.MAX_POINTS(Depth)) i_dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .pt_i  (pt),
    .fit_o (fit)
  );

  always #5 clk_i = ~clk_i;

  // long stretch without any idling on either side
  function automatic bit take_break();
    return (cycles < 30000 || cycles > 60000) && $urandom_range(99) < 10;
  endfunction

  function automatic logic signed [ResW-1:0] sat32(logic signed [127:0] v);
    if (v > 128'sh7FFF_FFFF) return 32'sh7FFF_FFFF;
    if (v < -128'sh8000_0000) return 32'sh8000_0000;
    return v[ResW-1:0];
  endfunction

  task automatic fit_point(point_t p);
    logic signed [127:0] num, den, icpt_num, acc, r;
    logic signed [ResW-1:0] sl, ic;
    fit_t f;
    if (n_pts < Depth) begin
      x_mem[n_pts] = p.x;
      y_mem[n_pts] = p.y;
      n_pts++;
      s_x  += longint'(p.x);
      s_y  += longint'(p.y);
      s_xx += longint'(p.x) * longint'(p.x);
      s_xy += longint'(p.x) * longint'(p.y);
    end
    if (!p.last) return;
    num = 128'(n_pts) * 128'(s_xy) - 128'(s_x) * 128'(s_y);
    den = 128'(n_pts) * 128'(s_xx) - 128'(s_x) * 128'(s_x);
    f = '0;
    if (den > 0) begin
      sl = sat32((num <<< 16) / den);
      icpt_num = 128'(s_y) * 128'sd65536 - 128'(sl) * 128'(s_x);
      ic = sat32(icpt_num / (128'sd256 * 128'(n_pts)));
      acc = '0;
      for (int i = 0; i < n_pts; i++) begin
        r = 128'(sl) * 128'(x_mem[i]) + 128'(ic) * 128'sd256
            - 128'(y_mem[i]) * 128'sd65536;
        acc += r * r;
      end
      f.slope = sl;
      f.intercept = ic;
      f.chi = (acc >= (128'sd1 <<< 80)) ? '1 : acc[79:32];
      f.ok = 1'b1;
    end
    fit_q.push_back(f);
    n_pts = 0; s_x = 0; s_y = 0; s_xx = 0; s_xy = 0;
  endtask

  // driver
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pt.valid <= 1'b0;
      pt.x_value <= '0;
      pt.y_value <= '0;
      pt.last_point <= 1'b0;
    end else if (!pt.valid || pt.ready) begin
      if (point_q.size() > 0 && !take_break()) begin
        point_t p;
        p = point_q.pop_front();
        fit_point(p);
        pt.valid <= 1'b1;
        pt.x_value <= p.x;
        pt.y_value <= p.y;
        pt.last_point <= p.last;
      end else begin
        pt.valid <= 1'b0;
      end
    end
  end

  // monitor
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fit.ready <= 1'b0;
    end else begin
      cycles <= cycles + 1;
      if (fit.valid && fit.ready) begin
        if (fit_q.size() == 0) begin
          $error("unexpected fit word");
          errors++;
        end else begin
          fit_t e;
          e = fit_q.pop_front();
          if (fit.slope !== e.slope) begin
            $error("slope: expected %0d, got %0d", e.slope, fit.slope);
            errors++;
          end
          if (fit.intercept !== e.intercept) begin
            $error("intercept: expected %0d, got %0d", e.intercept, fit.intercept);
            errors++;
          end
          if (fit.chi_squared !== e.chi) begin
            $error("chi_squared: expected %0d, got %0d", e.chi, fit.chi_squared);
            errors++;
          end
          if (fit.fit_ok !== e.ok) begin
            $error("fit_ok: expected %0b, got %0b", e.ok, fit.fit_ok);
            errors++;
          end
        end
      end
      fit.ready <= !take_break();
      if (cycles > Limit) begin
        $display("FAILED: results differ");
        $finish;
      end
    end
  end

  task automatic add_pt(int x, int y, bit last);
    point_t p;
    p.x = CoordW'(x);
    p.y = CoordW'(y);
    p.last = last;
    point_q.push_back(p);
  endtask

  task automatic add_set(int len, int span, bit same_x);
    int x0;
    x0 = $urandom_range(65535) - 32768;
    for (int i = 0; i < len; i++) begin
      int xv, yv;
      xv = same_x ? x0 : $urandom_range(2 * span) - span;
      yv = $urandom_range(2 * span) - span;
      add_pt(xv, yv, i == len - 1);
    end
  endtask

  initial begin
    int sent;
    int len;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed: single point, equal x, extremes, saturating slope, ordinary line
    add_pt(100, 200, 1'b1);
    add_pt(-32768, 5, 1'b0);
    add_pt(-32768, -9, 1'b1);
    add_pt(-32768, -32768, 1'b0);
    add_pt(32767, 32767, 1'b1);
    add_pt(0, -32768, 1'b0);
    add_pt(1, 32767, 1'b1);
    add_pt(0, 32767, 1'b0);
    add_pt(1, -32768, 1'b1);
    add_pt(-32768, 32767, 1'b0);
    add_pt(32767, -32768, 1'b0);
    add_pt(0, 0, 1'b1);
    add_pt(256, 512, 1'b0);
    add_pt(512, 768, 1'b0);
    add_pt(768, 1024, 1'b0);
    add_pt(1024, 1300, 1'b1);
    add_pt(-1, -1, 1'b0);
    add_pt(-1, 0, 1'b0);
    add_pt(0, 0, 1'b1);

    wait (point_q.size() == 0 && !pt.valid && fit_q.size() == 0);

    // store overflow: the points beyond the depth are dropped
    for (int i = 0; i < Depth + 6; i++)
      add_pt($urandom_range(65535) - 32768, $urandom_range(65535) - 32768,
             i == Depth + 5);

    sent = 0;
    while (sent < 520) begin
      case ($urandom_range(9))
        0: len = 1;
        1: len = $urandom_range(2, 60);
        default: len = $urandom_range(2, 10);
      endcase
      case ($urandom_range(5))
        0: add_set(len, 32767, 1'b1);
        1: add_set(len, 200, 1'b0);
        2: add_set(len, 4000, 1'b0);
        default: add_set(len, 32767, 1'b0);
      endcase
      sent += len;
      wait (point_q.size() < 64);
    end

    wait (point_q.size() == 0 && !pt.valid);
    wait (fit_q.size() == 0 || cycles > Limit);
    repeat (200) @(posedge clk_i);
    if (errors == 0 && fit_q.size() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
